FILE: sv/waveform_modulator_macros.svh
// Assertion macros shared by the waveform modulator RTL.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef WAVEFORM_MODULATOR_MACROS_SVH
`define WAVEFORM_MODULATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside of reset.
`define WM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("waveform_modulator: assertion failed");
// Next-cycle implication, checked outside of reset.
`define WM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("waveform_modulator: assertion failed");
`else
`define WM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/wm_pkg.sv
// Package for the waveform modulator: constants, register codes and flow types.
// No dependencies; all other files but the macros header import it.
`default_nettype none

package wm_pkg;

    // Number of register stages from the input beat to the output register.
    localparam int NS = 8;

    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 2'd3;

    // Waveform select codes; the fourth code passes the value through.
    localparam logic [1:0] WAVE_SINE  = 2'd0;
    localparam logic [1:0] WAVE_SAW   = 2'd1;
    localparam logic [1:0] WAVE_PULSE = 2'd2;

    // Register reset values.
    localparam logic [1:0]         RST_WAVE_TYPE = WAVE_SINE;
    localparam logic [31:0]        RST_AMPLITUDE = 32'h0001_0000;
    localparam logic signed [31:0] RST_BIAS      = 32'sh0000_8000;

    // One in Q16 as an 18-bit waveform sample.
    localparam logic signed [17:0] ONE_W = 18'sd65536;

    // Sine polynomial coefficients in Q16, and the Q48 constant term.
    localparam logic signed [19:0] SIN_C2  = -20'sd321126;
    localparam logic signed [18:0] SIN_C4  = 19'sd235930;
    localparam logic signed [51:0] ACC_ONE = 52'sh1_0000_0000_0000;
    localparam logic signed [51:0] ACC_HALF = 52'sh0_0000_8000_0000;

    // Rounding offset for the level scaling by 2^-17.
    localparam logic signed [50:0] PROD_HALF = 51'sd65536;

    // Pipeline flow control between the stage controller and the datapath.
    typedef struct packed {
        logic [NS-1:0] load;
        logic [NS-1:0] valid;
    } t_flow;

endpackage

`default_nettype wire

FILE: sv/wm_ifs.sv
// Channel interfaces of the waveform modulator: input items, results, register writes.
// Depends on wm_pkg for the register index width.
`default_nettype none

interface wm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] in_value;
    logic        [15:0] phase;

    modport source (output valid, output in_value, output phase, input ready);
    modport sink   (input valid, input in_value, input phase, output ready);
endinterface

interface wm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_value;

    modport source (output valid, output out_value, input ready);
    modport sink   (input valid, input out_value, output ready);
endinterface

interface wm_cfg_if import wm_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/waveform_modulator.sv
// Waveform modulator top: sine, saw or pulse level times the input, saturated, or bypass.
// Depends on wm_pkg, wm_ifs, wm_flow and the assertion macros header.
// Throughput: one beat per cycle unless all stages are full and the output stalls.
// Every stage is one register deep and holds while stalled.
// Reset: synchronous active-low; clears all valid bits and loads the registers' defaults.
`default_nettype none
`include "waveform_modulator_macros.svh"

module waveform_modulator import wm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    wm_in_if.sink    i_in,
    wm_cfg_if.sink   i_cfg,
    wm_out_if.source o_out
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; the user writes
    // them only while no beat is in flight.
    // ------------------------------------------------------------------
    logic [1:0]         r_wave_type;
    logic [31:0]        r_amplitude;
    logic signed [31:0] r_bias;
    logic               r_invert;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_type <= RST_WAVE_TYPE;
            r_amplitude <= RST_AMPLITUDE;
            r_bias      <= RST_BIAS;
            r_invert    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_WAVE_TYPE: r_wave_type <= i_cfg.data[1:0];
                REG_AMPLITUDE: r_amplitude <= i_cfg.data;
                REG_BIAS:      r_bias      <= i_cfg.data;
                REG_INVERT:    r_invert    <= i_cfg.data[0];
                default:       r_wave_type <= r_wave_type;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage register loads when empty or when its
    // content moves downstream, so the input keeps taking beats while a
    // finished result waits in the output register.
    // ------------------------------------------------------------------
    t_flow w_flow;

    wm_flow u_flow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_flow      (w_flow)
    );

    assign i_in.ready  = w_flow.load[0];
    assign o_out.valid = w_flow.valid[NS-1];

    // ------------------------------------------------------------------
    // Stage 1: fold the phase and square it. The folded argument
    // (2*phase - 1/2) mod 1, recentered, is just the low 15 phase bits
    // shifted up and read as signed.
    // ------------------------------------------------------------------
    logic signed [15:0] n_t1;
    logic signed [31:0] n_tt1;
    logic        [15:0] n_phq1;

    logic        [30:0] r_s1;
    logic               r_flip1;
    logic        [15:0] r_ph1;
    logic signed [31:0] r_x1;

    assign n_t1   = {i_in.phase[14:0], 1'b0};
    assign n_tt1  = n_t1 * n_t1;
    assign n_phq1 = i_in.phase - 16'h4000;

    always_ff @(posedge i_clk) begin
        if (w_flow.load[0]) begin
            r_s1    <= n_tt1[30:0];
            r_flip1 <= n_phq1[15];
            r_ph1   <= i_in.phase;
            r_x1    <= i_in.in_value;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: fourth power of the argument, kept as Q32.
    // ------------------------------------------------------------------
    logic        [61:0] n_ss2;

    logic        [30:0] r_s2;
    logic        [28:0] r_s2q2;
    logic               r_flip2;
    logic        [15:0] r_ph2;
    logic signed [31:0] r_x2;

    assign n_ss2 = r_s1 * r_s1;

    always_ff @(posedge i_clk) begin
        if (w_flow.load[1]) begin
            r_s2    <= r_s1;
            r_s2q2  <= n_ss2[60:32];
            r_flip2 <= r_flip1;
            r_ph2   <= r_ph1;
            r_x2    <= r_x1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: polynomial 1 + C2*s + C4*s^2 in Q48.
    // ------------------------------------------------------------------
    logic signed [51:0] n_c2s3;
    logic signed [51:0] n_c4s3;

    logic signed [51:0] r_acc3;
    logic               r_flip3;
    logic        [15:0] r_ph3;
    logic signed [31:0] r_x3;

    assign n_c2s3 = SIN_C2 * $signed({1'b0, r_s2});
    assign n_c4s3 = SIN_C4 * $signed({3'b000, r_s2q2});

    always_ff @(posedge i_clk) begin
        if (w_flow.load[2]) begin
            r_acc3  <= ACC_ONE + n_c2s3 + n_c4s3;
            r_flip3 <= r_flip2;
            r_ph3   <= r_ph2;
            r_x3    <= r_x2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: round the polynomial to Q16, pick the waveform and apply
    // the invert flag. The unused select code marks the beat as a
    // pass-through of the input value.
    // ------------------------------------------------------------------
    logic signed [51:0] n_rnd4;
    logic signed [17:0] n_poly4;
    logic signed [17:0] n_sine4;
    logic signed [17:0] n_saw4;
    logic signed [17:0] n_pulse4;
    logic signed [17:0] n_wave4;
    logic               n_byp4;

    logic signed [17:0] r_w4;
    logic               r_byp4;
    logic signed [31:0] r_x4;

    assign n_rnd4   = r_acc3 + ACC_HALF;
    assign n_poly4  = n_rnd4[49:32];
    assign n_sine4  = r_flip3 ? -n_poly4 : n_poly4;
    assign n_saw4   = $signed({1'b0, r_ph3, 1'b0}) - ONE_W;
    // Exactly one half still counts as the high level.
    assign n_pulse4 = (r_ph3 <= 16'h8000) ? ONE_W : -ONE_W;

    always_comb begin
        n_byp4 = 1'b0;
        case (r_wave_type)
            WAVE_SINE:  n_wave4 = n_sine4;
            WAVE_SAW:   n_wave4 = n_saw4;
            WAVE_PULSE: n_wave4 = n_pulse4;
            default: begin
                n_wave4 = '0;
                n_byp4  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_flow.load[3]) begin
            r_w4   <= r_invert ? -n_wave4 : n_wave4;
            r_byp4 <= n_byp4;
            r_x4   <= r_x3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: waveform times amplitude, Q32 product.
    // ------------------------------------------------------------------
    logic signed [50:0] r_prod5;
    logic               r_byp5;
    logic signed [31:0] r_x5;

    always_ff @(posedge i_clk) begin
        if (w_flow.load[4]) begin
            r_prod5 <= r_w4 * $signed({1'b0, r_amplitude});
            r_byp5  <= r_byp4;
            r_x5    <= r_x4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: level = bias + product/2^17, rounded half up. The level
    // spans [-2^32+1, 2^32-1] and needs 33 bits. The input magnitude is
    // taken here too.
    // ------------------------------------------------------------------
    logic signed [50:0] n_prnd6;
    logic signed [32:0] n_half6;
    logic        [31:0] n_ax6;

    logic signed [32:0] r_level6;
    logic        [31:0] r_ax6;
    logic               r_xneg6;
    logic               r_byp6;
    logic signed [31:0] r_x6;

    assign n_prnd6 = r_prod5 + PROD_HALF;
    assign n_half6 = n_prnd6[49:17];
    assign n_ax6   = r_x5[31] ? 32'h0 - r_x5 : r_x5;

    always_ff @(posedge i_clk) begin
        if (w_flow.load[5]) begin
            r_level6 <= $signed({r_bias[31], r_bias}) + n_half6;
            r_ax6    <= n_ax6;
            r_xneg6  <= r_x5[31];
            r_byp6   <= r_byp5;
            r_x6     <= r_x5;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: magnitude product. The level magnitude reaches 2^32 only
    // when it is exactly 2^32, so its top bit is handled as a shifted
    // add in the next stage and the multiplier stays 32 by 32.
    // ------------------------------------------------------------------
    logic        [32:0] n_al7;

    logic        [63:0] r_plo7;
    logic               r_hi7;
    logic        [31:0] r_ax7;
    logic               r_neg7;
    logic               r_byp7;
    logic signed [31:0] r_x7;

    assign n_al7 = r_level6[32] ? 33'h0 - r_level6 : r_level6;

    always_ff @(posedge i_clk) begin
        if (w_flow.load[6]) begin
            r_plo7 <= r_ax6 * n_al7[31:0];
            r_hi7  <= n_al7[32];
            r_ax7  <= r_ax6;
            r_neg7 <= r_xneg6 ^ r_level6[32];
            r_byp7 <= r_byp6;
            r_x7   <= r_x6;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: round the magnitude to Q16 (half away from zero once signed),
    // saturate to 32 bits or pass the input, and fill the output register.
    // ------------------------------------------------------------------
    logic        [63:0] n_full8;
    logic        [47:0] n_mag8;
    logic signed [31:0] n_out8;

    logic signed [31:0] r_out8;

    assign n_full8 = r_plo7 + (r_hi7 ? {r_ax7, 32'h0} : 64'h0) + 64'h8000;
    assign n_mag8  = n_full8[63:16];

    always_comb begin
        if (r_byp7) begin
            n_out8 = r_x7;
        end else if (r_neg7) begin
            if (n_mag8 >= 48'h0000_8000_0000) begin
                n_out8 = 32'sh8000_0000;
            end else begin
                n_out8 = 32'h0 - n_mag8[31:0];
            end
        end else begin
            if (n_mag8 > 48'h0000_7FFF_FFFF) begin
                n_out8 = 32'sh7FFF_FFFF;
            end else begin
                n_out8 = n_mag8[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_flow.load[7]) begin
            r_out8 <= n_out8;
        end
    end

    assign o_out.out_value = r_out8;

    // ------------------------------------------------------------------
    // Checks on the datapath.
    // ------------------------------------------------------------------
    `WM_ASSERT_IMP(a_wave_in_range, i_clk, i_rst_n, w_flow.valid[3], (r_w4 >= -ONE_W) && (r_w4 <= ONE_W))
    `WM_ASSERT_IMP(a_level_top_exact, i_clk, i_rst_n, w_flow.valid[6] && r_hi7, r_plo7 == 64'h0)
    `WM_ASSERT_NEXT(a_negative_sign, i_clk, i_rst_n, w_flow.valid[6] && w_flow.load[7] && !r_byp7 && r_neg7, r_out8[31] || (r_out8 == 32'sh0))

endmodule

`default_nettype wire

FILE: sv/wm_flow.sv
// Stage controller for the waveform modulator pipeline: valid bits and load enables.
// Depends on wm_pkg and the assertion macros header.
`default_nettype none
`include "waveform_modulator_macros.svh"

module wm_flow import wm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    output t_flow o_flow
);

    logic [NS-1:0] r_valid;
    logic [NS-1:0] n_valid;
    logic [NS-1:0] w_load;
    logic          w_in_acc;
    logic          w_out_acc;

    // A stage loads when it is empty or when its content moves on, so bubbles close up.
    always_comb begin
        w_load[NS-1] = !r_valid[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_load[k] = !r_valid[k] || w_load[k+1];
        end
    end

    assign n_valid = {r_valid[NS-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_load[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    assign o_flow.load  = w_load;
    assign o_flow.valid = r_valid;

    assign w_in_acc  = i_in_valid && w_load[0];
    assign w_out_acc = r_valid[NS-1] && i_out_ready;

    `WM_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, !w_load[0], &r_valid)
    `WM_ASSERT_NEXT(a_item_count, i_clk, i_rst_n, 1'b1, $countones(r_valid) == $past($countones(r_valid)) + int'($past(w_in_acc)) - int'($past(w_out_acc)))
    `WM_ASSERT_NEXT(a_first_stage_holds, i_clk, i_rst_n, r_valid[0] && !w_load[1], r_valid[0])

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the waveform modulator: sine, saw, pulse and pass-through levels.
// Depends on wm_pkg, the channel interfaces in wm_ifs and the waveform_modulator top level.

module tb_top;
    import wm_pkg::*;

    // The fourth select code has no name in the package; it passes the value through.
    localparam logic [1:0] WAVE_PASS = 2'd3;

    // Sine polynomial coefficients in Q16.
    localparam longint SINE_C2_Q16 = -321126;
    localparam longint SINE_C4_Q16 = 235930;

    // Cycles without any accepted beat before the run is declared hung.
    // The longest legal quiet stretch is the long output hold-off below.
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    logic clk;
    logic rst_n;

    wm_in_if  in_if ();
    wm_out_if out_if ();
    wm_cfg_if cfg_if ();

    waveform_modulator u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Our own copy of the four configuration registers, updated on each accepted write beat.
    logic [1:0]         cfg_wave;
    logic [31:0]        cfg_amp;
    logic signed [31:0] cfg_bias;
    logic               cfg_inv;

    // Modulated values predicted for accepted input beats, oldest first.
    logic signed [31:0] modulated_q[$];

    int  failures;
    int  idle_cycles;
    bit  idle_en;
    int  hold_req;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction of one result beat from one input beat and the current
    // register settings. The waveform sample is Q16 in [-1, +1], the level
    // is kept at full width, and only the final product is saturated.
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] modulate(input logic signed [31:0] value,
                                                   input logic [15:0] ph);
        logic [15:0]  folded;
        logic [15:0]  quarter;
        longint       t;
        longint       sq;
        longint       sq2;
        longint       acc;
        longint       poly;
        longint       w;
        longint       prod;
        longint       level;
        longint       xv;
        longint       res;
        logic [63:0]  ax;
        logic [63:0]  al;
        logic [127:0] mag;
        bit           neg;

        if (cfg_wave == WAVE_PASS)
            return value;

        case (cfg_wave)
            WAVE_SINE: begin
                // Fold to a half period centered on zero, evaluate the even
                // polynomial there, then flip the sign on the outer half.
                folded  = {ph[14:0], 1'b0} - 16'h8000;
                t       = longint'(folded) - 32768;
                sq      = t * t;
                sq2     = (sq * sq) >>> 32;
                acc     = (64'sd1 <<< 48) + SINE_C2_Q16 * sq + SINE_C4_Q16 * sq2;
                poly    = (acc + (64'sd1 <<< 31)) >>> 32;
                quarter = ph - 16'd16384;
                w       = quarter[15] ? -poly : poly;
            end
            WAVE_SAW: begin
                w = 2 * longint'(ph) - 65536;
            end
            default: begin
                // Pulse: exactly one half still counts as the high half.
                w = (ph <= 16'd32768) ? 65536 : -65536;
            end
        endcase

        prod = w * $signed({32'b0, cfg_amp});
        if (cfg_inv)
            prod = -prod;
        level = longint'(cfg_bias) + ((prod + 65536) >>> 17);

        // Rounding is done on the magnitude, so halves go away from zero.
        xv  = value;
        ax  = (xv < 0) ? -xv : xv;
        al  = (level < 0) ? -level : level;
        neg = (xv < 0) != (level < 0);
        mag = ({64'b0, ax} * {64'b0, al} + 128'd32768) >> 16;

        if (neg)
            res = (mag >= 128'h8000_0000) ? -64'sd2147483648 : -$signed({1'b0, mag[62:0]});
        else
            res = (mag > 128'h7fff_ffff) ? 64'sd2147483647 : $signed({1'b0, mag[62:0]});
        return res[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready is driven at the falling edge. Short random stalls
    // come while idling is enabled; a test can also ask for one long
    // hold-off, which this process counts out itself.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int n;
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                out_if.ready = 1'b0;
                repeat (n - 1) @(negedge clk);
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 9);
                out_if.ready = 1'b0;
                repeat (n - 1) @(negedge clk);
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    // Every accepted result beat is compared with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (modulated_q.size() == 0) begin
                $error("out_value beat %0d arrived with no prediction pending",
                       out_if.out_value);
                failures++;
            end else if (out_if.out_value !== modulated_q[0]) begin
                $error("out_value mismatch: expected %0d, actual %0d",
                       modulated_q[0], out_if.out_value);
                failures++;
                void'(modulated_q.pop_front());
            end else begin
                void'(modulated_q.pop_front());
            end
        end
    end

    // Watchdog: a hung handshake on any channel ends the run.
    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks. Inputs change only at the falling edge and the
    // handshake is judged at the rising edge.
    // ------------------------------------------------------------------

    // Sends one input beat, with an optional random gap in front of it, and
    // records its predicted result once the block has taken it.
    task automatic send_item(input logic signed [31:0] value, input logic [15:0] ph);
        int gap;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 9);
            repeat (gap) begin
                @(negedge clk);
                in_if.valid = 1'b0;
            end
        end
        @(negedge clk);
        in_if.valid    = 1'b1;
        in_if.in_value = value;
        in_if.phase    = ph;
        do @(posedge clk); while (!in_if.ready);
        modulated_q.push_back(modulate(value, ph));
    endtask

    // Stops offering input and waits for every predicted result to arrive.
    task automatic drain_results();
        @(negedge clk);
        in_if.valid = 1'b0;
        while (modulated_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            REG_WAVE_TYPE: cfg_wave = data[1:0];
            REG_AMPLITUDE: cfg_amp  = data;
            REG_BIAS:      cfg_bias = data;
            REG_INVERT:    cfg_inv  = data[0];
            default: ;
        endcase
    endtask

    // Registers are only rewritten once the pipeline is empty. The wave and
    // invert words carry random upper bits, which the block must ignore.
    task automatic apply_config(input logic [1:0] wave, input logic [31:0] amp,
                                input logic signed [31:0] bias, input logic inv);
        drain_results();
        write_reg(REG_WAVE_TYPE, ($urandom() & ~32'h3) | 32'(wave));
        write_reg(REG_AMPLITUDE, amp);
        write_reg(REG_BIAS, bias);
        write_reg(REG_INVERT, ($urandom() & ~32'h1) | 32'(inv));
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Random input fields, weighted toward the extremes and the phase points
    // where the waveforms turn or switch.
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic [15:0] rand_phase();
        case ($urandom_range(0, 11))
            0:       return 16'd0;
            1:       return 16'd16384;
            2:       return 16'd32768;
            3:       return 16'd32769;
            4:       return 16'd49152;
            5:       return 16'd65535;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic apply_random_config();
        logic [1:0]         wave;
        logic [31:0]        amp;
        logic signed [31:0] bias;
        case ($urandom_range(0, 9))
            0, 1, 2: wave = WAVE_SINE;
            3, 4, 5: wave = WAVE_SAW;
            6, 7, 8: wave = WAVE_PULSE;
            default: wave = WAVE_PASS;
        endcase
        case ($urandom_range(0, 5))
            0:       amp = 32'h0000_0000;
            1:       amp = 32'hffff_ffff;
            2:       amp = 32'h0001_0000;
            3:       amp = $urandom_range(0, 32'h0004_0000);
            default: amp = $urandom();
        endcase
        case ($urandom_range(0, 5))
            0:       bias = 32'sh8000_0000;
            1:       bias = 32'sh7fff_ffff;
            2:       bias = 32'sh0000_0000;
            3:       bias = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: bias = $signed($urandom());
        endcase
        apply_config(wave, amp, bias, 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: sine with unit amplitude around a bias of one half.
    task automatic test_reset_defaults();
        send_item(32'sh0001_0000, 16'd0);
        send_item(32'sh0001_0000, 16'd16384);
        send_item(32'sh0001_0000, 16'd32768);
        send_item(32'sh0001_0000, 16'd49152);
        send_item(32'sh7fff_ffff, 16'd0);
        send_item(32'sh8000_0000, 16'd32768);
    endtask

    // One short directed pass over each waveform and the register extremes.
    task automatic test_wave_shapes();
        // Pulse at full amplitude: exactly one half is high, one step past is low.
        // Large values drive the product into the positive saturation limit.
        apply_config(WAVE_PULSE, 32'hffff_ffff, 32'sh0000_0000, 1'b0);
        send_item(32'sh7fff_ffff, 16'd32768);
        send_item(32'sh8000_0000, 16'd32769);
        send_item(32'sh0001_0000, 16'd0);

        // Saw with no amplitude: the level is the most negative bias alone.
        apply_config(WAVE_SAW, 32'h0000_0000, 32'sh8000_0000, 1'b1);
        send_item(32'sh7fff_ffff, 16'd0);
        send_item(32'sh0000_0001, 16'd65535);
        send_item(32'sh8000_0000, 16'd32768);

        // Inverted sine at the largest amplitude and bias, off the quarter points.
        apply_config(WAVE_SINE, 32'hffff_ffff, 32'sh7fff_ffff, 1'b1);
        send_item(32'sh0000_8000, 16'd8192);
        send_item(32'shffff_8000, 16'd24576);
        send_item(32'sh0001_2345, 16'd40960);

        // The unused select code passes the value through untouched.
        apply_config(WAVE_PASS, 32'h0001_0000, 32'sh0000_8000, 1'b0);
        send_item(32'sh8000_0000, 16'($urandom_range(0, 65535)));
        send_item(32'sh7fff_ffff, 16'($urandom_range(0, 65535)));
        send_item(32'sh0000_0000, 16'($urandom_range(0, 65535)));
        send_item(32'shffff_ffff, 16'($urandom_range(0, 65535)));
    endtask

    // Several random settings, each with a run of random beats and random idling.
    task automatic test_random_settings();
        for (int p = 0; p < 8; p++) begin
            apply_random_config();
            repeat (100) send_item(rand_value(), rand_phase());
        end
    endtask

    // The result side holds off for a long stretch while input keeps coming,
    // so the pipeline fills and stalls its input; then the sender pauses until
    // every result is out.
    task automatic test_output_backpressure();
        apply_random_config();
        hold_req = LONG_HOLD;
        repeat (60) send_item(rand_value(), rand_phase());
        drain_results();
        repeat (20) send_item(rand_value(), rand_phase());
    endtask

    // Closing stretch with no idling on either side: one beat per cycle.
    task automatic test_back_to_back();
        idle_en = 1'b0;
        repeat (2) begin
            apply_random_config();
            repeat (100) send_item(rand_value(), rand_phase());
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        in_if.valid    = 1'b0;
        in_if.in_value = '0;
        in_if.phase    = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = REG_WAVE_TYPE;
        cfg_if.data    = '0;
        failures       = 0;
        idle_cycles    = 0;
        hold_req       = 0;
        idle_en        = 1'b1;

        // Model registers start from their reset values.
        cfg_wave = RST_WAVE_TYPE;
        cfg_amp  = RST_AMPLITUDE;
        cfg_bias = RST_BIAS;
        cfg_inv  = 1'b0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_wave_shapes();
        test_random_settings();
        test_output_backpressure();
        test_back_to_back();

        // Let the last results out, then watch a little longer for stray beats.
        drain_results();
        repeat (2 * NS) @(posedge clk);

        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
